/* hw/rtl/pis_pkg.sv */
`timescale 1ns / 1ps

package pis_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = DATA_W + 1;
    localparam int DELTA_W   = DATA_W + 2;
    localparam int INTEG_W   = DATA_W + 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WEIGHT_W  = 9;
    localparam int MUL_A_W   = CFG_W + WEIGHT_W + 1;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 45;
    localparam int WEIGHT_FRAC = 8;
    localparam int OUT_SHIFT = 16;
    localparam int OUT_W     = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL        = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_POINT_EIGHT = 9'd205;
    localparam logic [WEIGHT_W-1:0] WEIGHT_POINT_SIX   = 9'd154;
    localparam logic [WEIGHT_W-1:0] WEIGHT_POINT_TWO   = 9'd51;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_INTEG_LIM  = 3'd3,
        CFG_BAND_ONE   = 3'd4,
        CFG_BAND_TWO   = 3'd5,
        CFG_BAND_THREE = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_W,
        ST_MUL_I,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_DERIV,
        MUL_WEIGHT,
        MUL_INTEG
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD_SHIFT
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        logic     prep;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/pis_in_if.sv */
`timescale 1ns / 1ps

interface pis_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   target_value;
    logic signed [15:0]   measured_value;

    modport source (output valid, output target_value, output measured_value, input ready);
    modport sink (input valid, input target_value, input measured_value, output ready);
endinterface

/* hw/rtl/pis_out_if.sv */
`timescale 1ns / 1ps

interface pis_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   drive_value;
    logic                 drive_saturated;

    modport source (output valid, output drive_value, output drive_saturated, input ready);
    modport sink (input valid, input drive_value, input drive_saturated, output ready);
endinterface

/* hw/rtl/pid_integral_separation.sv */
`timescale 1ns / 1ps

// positional pid controller with integral separation and anti-windup
// sample: sink channel, one beat carries target_value and measured_value
// drive: source channel, one beat carries drive_value and drive_saturated
// cfg_we / cfg_index / cfg_data: register writes, taken on any edge with cfg_we
// high; index 0..6 selects prop_gain, integ_gain, deriv_gain, integ_limit,
// band_one, band_two, band_three; other indexes are dropped
// each accepted beat yields exactly one drive beat
// each sample passes the states PREP, MUL_P, MUL_D, MUL_W, MUL_I and WRITE, and
// no new sample is taken before its result is in the output register; the pace
// is set by the single shared 26x18 multiplier, used four times per sample
// sample.ready is high only while the controller is idle
// if drive stalls, the finished result waits in the output register and the
// next result is held in the datapath until that register frees up
// reset clears the previous error and the integral to zero and loads the
// registers with their default values; no result is pending after reset
module pid_integral_separation (
    input  logic                            clk,
    input  logic                            rst_n,
    pis_in_if.sink                          sample,
    pis_out_if.source                       drive,
    input  logic                            cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pis_pkg::CFG_W-1:0]       cfg_data
);
    import pis_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    pis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    pis_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_value    (sample.target_value),
        .measured_value  (sample.measured_value),
        .drive_value     (drive.drive_value),
        .drive_saturated (drive.drive_saturated),
        .out_valid       (drive.valid),
        .out_ready       (drive.ready)
    );

    assign sample.ready = in_ready;

endmodule

/* hw/rtl/pis_ctrl.sv */
`timescale 1ns / 1ps

module pis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output pis_pkg::dp_cmd_t    cmd,
    input  pis_pkg::dp_status_t status
);
    import pis_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_MUL_W;
            ST_MUL_W: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.prep     = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_sel  = MUL_PROP;
        cmd.acc_op   = ACC_HOLD;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cmd.acc_op = ACC_CLEAR;
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                cmd.acc_op  = ACC_ADD_SHIFT;
            end
            ST_MUL_W:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WEIGHT;
                cmd.acc_op  = ACC_ADD_SHIFT;
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
            end
            ST_WRITE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/pis_datapath.sv */
`timescale 1ns / 1ps

module pis_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pis_pkg::dp_cmd_t                       cmd,
    output pis_pkg::dp_status_t                    status,
    input  logic                                   cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pis_pkg::CFG_W-1:0]              cfg_data,
    input  logic signed [pis_pkg::DATA_W-1:0]      target_value,
    input  logic signed [pis_pkg::DATA_W-1:0]      measured_value,
    output logic signed [pis_pkg::OUT_W-1:0]       drive_value,
    output logic                                   drive_saturated,
    output logic                                   out_valid,
    input  logic                                   out_ready
);
    import pis_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] prop_gain_reg;
    logic [CFG_W-1:0] integ_gain_reg;
    logic [CFG_W-1:0] deriv_gain_reg;
    logic [CFG_W-1:0] integ_limit_reg;
    logic [CFG_W-1:0] band_one_reg;
    logic [CFG_W-1:0] band_two_reg;
    logic [CFG_W-1:0] band_three_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= 16'd2560;
            integ_gain_reg  <= 16'd205;
            deriv_gain_reg  <= 16'd256;
            integ_limit_reg <= 16'd1000;
            band_one_reg    <= 16'd10;
            band_two_reg    <= 16'd50;
            band_three_reg  <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  prop_gain_reg   <= cfg_data;
                CFG_INTEG_GAIN: integ_gain_reg  <= cfg_data;
                CFG_DERIV_GAIN: deriv_gain_reg  <= cfg_data;
                CFG_INTEG_LIM:  integ_limit_reg <= cfg_data;
                CFG_BAND_ONE:   band_one_reg    <= cfg_data;
                CFG_BAND_TWO:   band_two_reg    <= cfg_data;
                CFG_BAND_THREE: band_three_reg  <= cfg_data;
                default:        prop_gain_reg   <= prop_gain_reg;
            endcase
        end
    end

    // sample capture
    logic signed [DATA_W-1:0] target_reg;
    logic signed [DATA_W-1:0] measured_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            target_reg   <= target_value;
            measured_reg <= measured_value;
        end
    end

    // error, band weight and integral update
    logic signed [ERR_W-1:0]    err;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [ERR_W-1:0]    b1;
    logic signed [ERR_W-1:0]    b2;
    logic signed [ERR_W-1:0]    b3;
    logic [WEIGHT_W-1:0]        weight;
    logic signed [INTEG_W-1:0]  lim;
    logic signed [INTEG_W-1:0]  err_x;
    logic signed [INTEG_W-1:0]  integ_next;

    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [WEIGHT_W-1:0]        weight_reg;

    always_comb
    begin
        err   = ERR_W'(target_reg) - ERR_W'(measured_reg);
        delta = DELTA_W'(err) - DELTA_W'(prev_err_reg);
        b1    = $signed({1'b0, band_one_reg});
        b2    = $signed({1'b0, band_two_reg});
        b3    = $signed({1'b0, band_three_reg});
        priority if (err < b1 && err > -b1)
        begin
            weight = WEIGHT_FULL;
        end
        else if (err < b2 && err > -b2)
        begin
            weight = WEIGHT_POINT_EIGHT;
        end
        else if (err < b3 && err > -b3)
        begin
            weight = WEIGHT_POINT_SIX;
        end
        else
        begin
            weight = WEIGHT_POINT_TWO;
        end

        lim   = $signed({2'b00, integ_limit_reg});
        err_x = INTEG_W'(err);
        priority if (integ_reg > -lim && integ_reg < lim)
        begin
            integ_next = integ_reg + err_x;
        end
        else if (integ_reg >= lim)
        begin
            integ_next = (err < 0) ? integ_reg + err_x : lim;
        end
        else
        begin
            integ_next = (err > 0) ? integ_reg + err_x : -lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end
        else if (cmd.prep)
        begin
            prev_err_reg <= err;
            integ_reg    <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            err_reg    <= err;
            delta_reg  <= delta;
            weight_reg <= weight;
        end
    end

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_PROP:
            begin
                mul_a = $signed(MUL_A_W'(prop_gain_reg));
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_DERIV:
            begin
                mul_a = $signed(MUL_A_W'(deriv_gain_reg));
                mul_b = MUL_B_W'(delta_reg);
            end
            MUL_WEIGHT:
            begin
                mul_a = $signed(MUL_A_W'(integ_gain_reg));
                mul_b = $signed(MUL_B_W'(weight_reg));
            end
            MUL_INTEG:
            begin
                mul_a = $signed({1'b0, prod_reg[MUL_A_W-2:0]});
                mul_b = MUL_B_W'(integ_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // accumulator
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_shift;

    assign prod_shift = $signed({prod_reg[ACC_W-WEIGHT_FRAC-1:0], {WEIGHT_FRAC{1'b0}}});

    always_ff @(posedge clk)
    begin
        unique case (cmd.acc_op)
            ACC_CLEAR:     acc_reg <= '0;
            ACC_ADD_SHIFT: acc_reg <= acc_reg + prod_shift;
            ACC_HOLD:      acc_reg <= acc_reg;
            default:       acc_reg <= acc_reg;
        endcase
    end

    // final sum, shift and saturation
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] out_max;
    logic signed [ACC_W-1:0] out_min;
    logic signed [OUT_W-1:0] res;
    logic                    res_sat;

    always_comb
    begin
        total   = acc_reg + ACC_W'(prod_reg);
        scaled  = total >>> OUT_SHIFT;
        out_max = ACC_W'({1'b0, {(OUT_W-1){1'b1}}});
        out_min = -out_max - ACC_W'(1);
        priority if (scaled > out_max)
        begin
            res     = out_max[OUT_W-1:0];
            res_sat = 1'b1;
        end
        else if (scaled < out_min)
        begin
            res     = out_min[OUT_W-1:0];
            res_sat = 1'b1;
        end
        else
        begin
            res     = scaled[OUT_W-1:0];
            res_sat = 1'b0;
        end
    end

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] drive_value_reg;
    logic                    drive_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            drive_value_reg <= res;
            drive_sat_reg   <= res_sat;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign drive_value     = drive_value_reg;
    assign drive_saturated = drive_sat_reg;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] value;
    logic               sat;
} drive_beat_t;

class pid_scoreboard;
    logic [15:0]        kp_reg;
    logic [15:0]        ki_reg;
    logic [15:0]        kd_reg;
    logic [15:0]        lim_reg;
    logic [15:0]        band1_reg;
    logic [15:0]        band2_reg;
    logic [15:0]        band3_reg;
    logic signed [16:0] last_err;
    logic signed [17:0] integ_acc;
    drive_beat_t        expected_q[$];
    int                 errors;

    function new();
        kp_reg    = 16'd2560;
        ki_reg    = 16'd205;
        kd_reg    = 16'd256;
        lim_reg   = 16'd1000;
        band1_reg = 16'd10;
        band2_reg = 16'd50;
        band3_reg = 16'd100;
        last_err  = '0;
        integ_acc = '0;
        errors    = 0;
    endfunction

    function void set_reg(logic [pis_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            pis_pkg::CFG_PROP_GAIN:  kp_reg    = val;
            pis_pkg::CFG_INTEG_GAIN: ki_reg    = val;
            pis_pkg::CFG_DERIV_GAIN: kd_reg    = val;
            pis_pkg::CFG_INTEG_LIM:  lim_reg   = val;
            pis_pkg::CFG_BAND_ONE:   band1_reg = val;
            pis_pkg::CFG_BAND_TWO:   band2_reg = val;
            pis_pkg::CFG_BAND_THREE: band3_reg = val;
            default: ;
        endcase
    endfunction

    function bit in_band(longint e, logic [15:0] b);
        longint lb;
        lb = longint'(b);
        return (e < lb) && (e > -lb);
    endfunction

    function void note_sample(logic signed [15:0] t, logic signed [15:0] m);
        logic signed [16:0] e;
        logic signed [17:0] d;
        longint             ee, dd, w, lim, acc, kp, ki, kd, sum, res;
        drive_beat_t        want;
        e  = 17'(t) - 17'(m);
        d  = 18'(e) - 18'(last_err);
        ee = longint'(e);
        dd = longint'(d);
        if (in_band(ee, band1_reg))
            w = longint'(pis_pkg::WEIGHT_FULL);
        else if (in_band(ee, band2_reg))
            w = longint'(pis_pkg::WEIGHT_POINT_EIGHT);
        else if (in_band(ee, band3_reg))
            w = longint'(pis_pkg::WEIGHT_POINT_SIX);
        else
            w = longint'(pis_pkg::WEIGHT_POINT_TWO);
        // anti-windup: only add error pointing back inward once at a limit
        lim = longint'(lim_reg);
        acc = longint'(integ_acc);
        if (acc > -lim && acc < lim)
            acc = acc + ee;
        else if (acc >= lim)
            acc = (ee < 0) ? acc + ee : lim;
        else
            acc = (ee > 0) ? acc + ee : -lim;
        integ_acc = acc[17:0];
        last_err  = e;
        kp  = longint'(kp_reg);
        ki  = longint'(ki_reg);
        kd  = longint'(kd_reg);
        sum = kp * ee * 256 + ki * w * acc + kd * dd * 256;
        res = sum >>> pis_pkg::OUT_SHIFT;
        want.sat = 1'b0;
        if (res > 64'sd2147483647)
        begin
            res      = 64'sd2147483647;
            want.sat = 1'b1;
        end
        else if (res < -64'sd2147483648)
        begin
            res      = -64'sd2147483648;
            want.sat = 1'b1;
        end
        want.value = res[31:0];
        expected_q.push_back(want);
    endfunction

    function void check_drive(logic signed [31:0] v, logic s);
        drive_beat_t want;
        if (expected_q.size() == 0)
        begin
            $error("drive beat with nothing expected: drive_value %0d", v);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (v !== want.value)
        begin
            $error("drive_value: expected %0d, got %0d", want.value, v);
            errors++;
        end
        if (s !== want.sat)
        begin
            $error("drive_saturated: expected %0d, got %0d", want.sat, s);
            errors++;
        end
    endfunction
endclass

module tb;
    import pis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 123;
    localparam int IDLE_PCT      = 19;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 3000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   tx_idle_on;
    bit                   rx_idle_on;
    bit                   hold_req;
    int                   stall_cnt = 0;
    pid_scoreboard        sb;

    pis_in_if  in_if ();
    pis_out_if out_if ();

    pid_integral_separation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (in_if),
        .drive     (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (in_if.valid && in_if.ready)
            sb.note_sample(in_if.target_value, in_if.measured_value);
        if (out_if.valid && out_if.ready)
            sb.check_drive(out_if.drive_value, out_if.drive_saturated);
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // drive side: random stalls plus one long hold-off on request
    initial
    begin
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_if.ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_beat(input logic [15:0] t, input logic [15:0] m);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.target_value   <= t;
        in_if.measured_value <= m;
        do
            @(posedge clk);
        while (!in_if.ready);
    endtask

    task automatic send_random_beat();
        logic [15:0] t;
        logic [15:0] m;
        int          pick;
        pick = $urandom_range(99);
        t    = 16'($urandom);
        if (pick < 55)
            m = t + 16'($urandom_range(800)) - 16'd400;
        else if (pick < 70)
        begin
            t = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            m = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            if ($urandom_range(1))
                m = 16'($urandom);
        end
        else
            m = 16'($urandom);
        send_beat(t, m);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [15:0] lim,
                                 input logic [15:0] b1, input logic [15:0] b2,
                                 input logic [15:0] b3);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_INTEG_LIM, lim);
        write_reg(CFG_BAND_ONE, b1);
        write_reg(CFG_BAND_TWO, b2);
        write_reg(CFG_BAND_THREE, b3);
        // out-of-range index must be dropped
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_gain();
        return ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4096));
    endfunction

    initial
    begin
        int          p;
        int          i;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] b3;
        logic [15:0] lim;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_if.valid          = 1'b0;
        in_if.target_value   = '0;
        in_if.measured_value = '0;
        tx_idle_on           = 1'b1;
        rx_idle_on           = 1'b1;
        hold_req             = 1'b0;
        sb                   = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // band edges and extremes at reset settings
        send_beat(16'sd0, 16'sd0);
        send_beat(16'sd9, 16'sd0);
        send_beat(16'sd0, 16'sd10);
        send_beat(16'sd49, 16'sd0);
        send_beat(16'sd0, 16'sd50);
        send_beat(16'sd99, 16'sd0);
        send_beat(16'sd100, 16'sd0);
        send_beat(-16'sd100, 16'sd0);
        // drive the integral past the upper limit, then clamp and pull back
        send_beat(16'sh7fff, 16'sh8000);
        send_beat(16'sh7fff, 16'sh8000);
        send_beat(16'sh8000, 16'sh7fff);
        send_beat(16'sh8000, 16'sh7fff);
        send_beat(16'sd100, 16'sd0);
        send_beat(16'hffff, 16'hffff);
        send_beat(16'sh7fff, 16'sh7fff);
        drain();

        // zero limit with unordered bands
        apply_setting(16'hffff, 16'hffff, 16'hffff, 16'd0, 16'd200, 16'd50, 16'd20);
        send_beat(16'sd0, 16'sd0);
        send_beat(16'sd5, 16'sd0);
        send_beat(-16'sd5, 16'sd0);
        send_beat(-16'sd3, 16'sd0);
        send_beat(16'sd30, 16'sd0);
        send_beat(16'sd150, 16'sd0);
        send_beat(16'sd250, 16'sd0);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            b1  = 16'($urandom_range(150));
            b2  = b1 + 16'($urandom_range(150));
            b3  = b2 + 16'($urandom_range(300));
            lim = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(3000));
            case (p)
                0: apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 16'hffff, 16'hffff, 16'hffff);
                1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: apply_setting(rand_gain(), rand_gain(), rand_gain(), 16'd0, b1, b2, b3);
                3: apply_setting(rand_gain(), rand_gain(), rand_gain(), lim, b3, b2, b1);
                9: apply_setting(16'd2560, 16'd205, 16'd256, 16'd1000,
                                 16'd10, 16'd50, 16'd100);
                default: apply_setting(rand_gain(), rand_gain(), rand_gain(), lim,
                                       b1, b2, b3);
            endcase
            tx_idle_on = (p != 5);
            rx_idle_on = (p != 5);
            if (p == 6)
                hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random_beat();
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
